@@ sv/w5r_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and rounding helpers for the WENO5 face reconstruction unit.
// Depends on nothing; every other file but w5r_dly refers to it by scoped names.
package w5r_pkg;

  typedef logic [63:0] w5r_dbl_t;

  localparam int unsigned ADD_LAT  = 5;
  localparam int unsigned MUL_LAT  = 5;
  localparam int unsigned QBITS    = 57;
  localparam int unsigned DIV_LAT  = QBITS + 4;
  localparam int unsigned LANE_LAT = 6 * MUL_LAT + 8 * ADD_LAT + 2 * DIV_LAT;

  localparam logic [1:0] KIND_NUM  = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_INF  = 2'd2;
  localparam logic [1:0] KIND_NAN  = 2'd3;

  localparam w5r_dbl_t CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam w5r_dbl_t C_ONE     = 64'h3FF0_0000_0000_0000;
  localparam w5r_dbl_t C_TWO     = 64'h4000_0000_0000_0000;
  localparam w5r_dbl_t C_THREE   = 64'h4008_0000_0000_0000;
  localparam w5r_dbl_t C_FOUR    = 64'h4010_0000_0000_0000;
  localparam w5r_dbl_t C_FIVE    = 64'h4014_0000_0000_0000;
  localparam w5r_dbl_t C_SEVEN   = 64'h401C_0000_0000_0000;
  localparam w5r_dbl_t C_ELEVEN  = 64'h4026_0000_0000_0000;
  localparam w5r_dbl_t C_QUARTER = 64'h3FD0_0000_0000_0000;
  localparam w5r_dbl_t C_SIXTH   = 64'h3FC5_5555_5555_5555;
  localparam w5r_dbl_t C_BETA_A  = 64'h3FF1_5555_5555_5555;
  localparam w5r_dbl_t C_EPS     = 64'h37A1_6C26_2777_579C;
  localparam w5r_dbl_t C_LIN [3] = '{64'h3FB9_9999_9999_999A,
                                     64'h3FE3_3333_3333_3333,
                                     64'h3FD3_3333_3333_3333};

  // Unrounded value: man holds 56 bits, leading one at bit 55, sticky in bit 0.
  typedef struct packed {
    logic              sgn;
    logic [1:0]        kind;
    logic signed [12:0] ex;
    logic [55:0]       man;
  } w5r_unr_t;

  function automatic w5r_dbl_t w5r_neg(w5r_dbl_t x);
    return {~x[63], x[62:0]};
  endfunction

  function automatic logic [7:0] w5r_lzc(logic [127:0] v);
    logic [7:0] n;
    n = 8'd128;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) n = 8'(127 - i);
    end
    return n;
  endfunction

  function automatic w5r_unr_t w5r_denorm(w5r_unr_t u);
    w5r_unr_t    r;
    logic [13:0] sh;
    logic [55:0] msk;
    r   = u;
    sh  = 14'd1 - {u.ex[12], u.ex};
    msk = ~({56{1'b1}} << sh[5:0]);
    if (u.kind == KIND_NUM && (u.ex[12] || u.ex == '0)) begin
      if (sh >= 14'd56) begin
        r.man = {55'b0, |u.man};
      end else begin
        r.man = (u.man >> sh[5:0]) | {55'b0, |(u.man & msk)};
      end
      r.ex = '0;
    end
    return r;
  endfunction

  function automatic w5r_dbl_t w5r_round(w5r_unr_t u);
    logic     inc;
    w5r_dbl_t r;
    inc = u.man[2] & (u.man[3] | u.man[1] | u.man[0]);
    r   = {u.sgn, u.ex[10:0], u.man[54:3]} + {63'b0, inc};
    case (u.kind)
      KIND_NAN:  r = CANON_NAN;
      KIND_INF:  r = {u.sgn, 11'h7FF, 52'b0};
      KIND_ZERO: r = {u.sgn, 63'b0};
      default: begin
        if (!u.ex[12] && u.ex[11:0] >= 12'd2047) r = {u.sgn, 11'h7FF, 52'b0};
      end
    endcase
    return r;
  endfunction

endpackage

@@ sv/w5r_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: one six-cell window per transaction.
// Depends on w5r_pkg.
interface w5r_in_if;
  logic              valid;
  logic              ready;
  w5r_pkg::w5r_dbl_t cell_a;
  w5r_pkg::w5r_dbl_t cell_b;
  w5r_pkg::w5r_dbl_t cell_c;
  w5r_pkg::w5r_dbl_t cell_d;
  w5r_pkg::w5r_dbl_t cell_e;
  w5r_pkg::w5r_dbl_t cell_f;
  modport source (output valid, cell_a, cell_b, cell_c, cell_d, cell_e, cell_f,
                  input ready);
  modport sink (input valid, cell_a, cell_b, cell_c, cell_d, cell_e, cell_f,
                output ready);
endinterface

@@ sv/w5r_out_if.sv @@
`timescale 1ns / 1ps
// Result channel: left and right face states per transaction.
// Depends on w5r_pkg.
interface w5r_out_if;
  logic              valid;
  logic              ready;
  w5r_pkg::w5r_dbl_t left_state;
  w5r_pkg::w5r_dbl_t right_state;
  modport source (output valid, left_state, right_state, input ready);
  modport sink (input valid, left_state, right_state, output ready);
endinterface

@@ sv/w5r_dly.sv @@
`timescale 1ns / 1ps
// Enabled delay line used to align operands inside a lane.
// Depends on nothing.
module w5r_dly #(
  parameter int unsigned DEPTH = 1,
  parameter int unsigned W     = 64
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];
endmodule

@@ sv/w5r_fadd.sv @@
`timescale 1ns / 1ps
// Pipelined binary64 adder, round to nearest even, ADD_LAT stages.
// Depends on w5r_pkg.
module w5r_fadd (
  input  logic              clk,
  input  logic              en,
  input  w5r_pkg::w5r_dbl_t a,
  input  w5r_pkg::w5r_dbl_t b,
  output w5r_pkg::w5r_dbl_t y
);
  typedef struct packed {
    logic        sgn;
    logic        zsgn;
    logic [1:0]  kind;
    logic        sub;
    logic [10:0] ex;
    logic [55:0] big;
    logic [55:0] sml;
  } al_t;

  typedef struct packed {
    logic        sgn;
    logic        zsgn;
    logic [1:0]  kind;
    logic [10:0] ex;
    logic [56:0] sum;
  } sm_t;

  al_t               al_nxt, al_r;
  sm_t               sm_nxt, sm_r;
  w5r_pkg::w5r_unr_t nm_nxt, nm_r, dn_r;
  w5r_pkg::w5r_dbl_t y_r;

  always_comb begin
    logic              swap, an, bn, ai, bi;
    w5r_pkg::w5r_dbl_t hi, lo;
    logic [10:0]       eh, el, d;
    logic [55:0]       ls, msk;
    an   = a[62:52] == 11'h7FF && a[51:0] != '0;
    bn   = b[62:52] == 11'h7FF && b[51:0] != '0;
    ai   = a[62:52] == 11'h7FF && a[51:0] == '0;
    bi   = b[62:52] == 11'h7FF && b[51:0] == '0;
    swap = b[62:0] > a[62:0];
    hi   = swap ? b : a;
    lo   = swap ? a : b;
    eh   = (hi[62:52] == '0) ? 11'd1 : hi[62:52];
    el   = (lo[62:52] == '0) ? 11'd1 : lo[62:52];
    d    = eh - el;
    ls   = {lo[62:52] != '0, lo[51:0], 3'b0};
    msk  = ~({56{1'b1}} << d[5:0]);
    al_nxt.big  = {hi[62:52] != '0, hi[51:0], 3'b0};
    al_nxt.sml  = (d >= 11'd56) ? {55'b0, |ls}
                                : ((ls >> d[5:0]) | {55'b0, |(ls & msk)});
    al_nxt.ex   = eh;
    al_nxt.sub  = a[63] ^ b[63];
    al_nxt.zsgn = a[63] & b[63];
    al_nxt.sgn  = hi[63];
    al_nxt.kind = w5r_pkg::KIND_NUM;
    if (an || bn || (ai && bi && a[63] != b[63])) begin
      al_nxt.kind = w5r_pkg::KIND_NAN;
    end else if (ai || bi) begin
      al_nxt.kind = w5r_pkg::KIND_INF;
      al_nxt.sgn  = ai ? a[63] : b[63];
    end
  end

  always_comb begin
    sm_nxt.sgn  = al_r.sgn;
    sm_nxt.zsgn = al_r.zsgn;
    sm_nxt.kind = al_r.kind;
    sm_nxt.ex   = al_r.ex;
    sm_nxt.sum  = al_r.sub ? ({1'b0, al_r.big} - {1'b0, al_r.sml})
                           : ({1'b0, al_r.big} + {1'b0, al_r.sml});
  end

  always_comb begin
    logic [7:0]  lz;
    logic [56:0] sn;
    lz = w5r_pkg::w5r_lzc({sm_r.sum, 71'b0});
    sn = sm_r.sum << lz;
    nm_nxt.sgn  = sm_r.sgn;
    nm_nxt.kind = sm_r.kind;
    nm_nxt.ex   = 13'({2'b0, sm_r.ex} + 13'd1 - {5'b0, lz});
    nm_nxt.man  = {sn[56:2], |sn[1:0]};
    if (sm_r.kind == w5r_pkg::KIND_NUM && sm_r.sum == '0) begin
      nm_nxt.kind = w5r_pkg::KIND_ZERO;
      nm_nxt.sgn  = sm_r.zsgn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al_r <= al_nxt;
      sm_r <= sm_nxt;
      nm_r <= nm_nxt;
      dn_r <= w5r_pkg::w5r_denorm(nm_r);
      y_r  <= w5r_pkg::w5r_round(dn_r);
    end
  end

  assign y = y_r;
endmodule

@@ sv/w5r_fmul.sv @@
`timescale 1ns / 1ps
// Pipelined binary64 multiplier, partial products of 32-bit and 21-bit operand halves, MUL_LAT stages.
// Depends on w5r_pkg.
module w5r_fmul (
  input  logic              clk,
  input  logic              en,
  input  w5r_pkg::w5r_dbl_t a,
  input  w5r_pkg::w5r_dbl_t b,
  output w5r_pkg::w5r_dbl_t y
);
  typedef struct packed {
    logic        sgn;
    logic [1:0]  kind;
    logic [11:0] exs;
    logic [63:0] pll;
    logic [52:0] plh;
    logic [52:0] phl;
    logic [41:0] phh;
  } pp_t;

  typedef struct packed {
    logic         sgn;
    logic [1:0]   kind;
    logic [11:0]  exs;
    logic [105:0] p;
  } pr_t;

  pp_t               pp_nxt, pp_r;
  pr_t               pr_nxt, pr_r;
  w5r_pkg::w5r_unr_t nm_nxt, nm_r, dn_r;
  w5r_pkg::w5r_dbl_t y_r;

  always_comb begin
    logic        an, bn, ai, bi, az, bz;
    logic [52:0] ga, gb;
    logic [10:0] xa, xb;
    an = a[62:52] == 11'h7FF && a[51:0] != '0;
    bn = b[62:52] == 11'h7FF && b[51:0] != '0;
    ai = a[62:52] == 11'h7FF && a[51:0] == '0;
    bi = b[62:52] == 11'h7FF && b[51:0] == '0;
    az = a[62:0] == '0;
    bz = b[62:0] == '0;
    xa = (a[62:52] == '0) ? 11'd1 : a[62:52];
    xb = (b[62:52] == '0) ? 11'd1 : b[62:52];
    ga = {a[62:52] != '0, a[51:0]};
    gb = {b[62:52] != '0, b[51:0]};
    pp_nxt.sgn = a[63] ^ b[63];
    pp_nxt.exs = {1'b0, xa} + {1'b0, xb};
    pp_nxt.pll = ga[31:0] * gb[31:0];
    pp_nxt.plh = ga[31:0] * gb[52:32];
    pp_nxt.phl = ga[52:32] * gb[31:0];
    pp_nxt.phh = ga[52:32] * gb[52:32];
    if (an || bn || (ai && bz) || (az && bi)) pp_nxt.kind = w5r_pkg::KIND_NAN;
    else if (ai || bi)                        pp_nxt.kind = w5r_pkg::KIND_INF;
    else if (az || bz)                        pp_nxt.kind = w5r_pkg::KIND_ZERO;
    else                                      pp_nxt.kind = w5r_pkg::KIND_NUM;
  end

  always_comb begin
    pr_nxt.sgn  = pp_r.sgn;
    pr_nxt.kind = pp_r.kind;
    pr_nxt.exs  = pp_r.exs;
    pr_nxt.p    = {42'b0, pp_r.pll} + ({53'b0, pp_r.plh} << 32)
                + ({53'b0, pp_r.phl} << 32) + ({64'b0, pp_r.phh} << 64);
  end

  always_comb begin
    logic [7:0]   lz;
    logic [105:0] pn;
    lz = w5r_pkg::w5r_lzc({pr_r.p, 22'b0});
    pn = pr_r.p << lz;
    nm_nxt.sgn  = pr_r.sgn;
    nm_nxt.kind = pr_r.kind;
    nm_nxt.ex   = 13'({1'b0, pr_r.exs} - 13'd1022 - {5'b0, lz});
    nm_nxt.man  = {pn[105:51], |pn[50:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      pr_r <= pr_nxt;
      nm_r <= nm_nxt;
      dn_r <= w5r_pkg::w5r_denorm(nm_r);
      y_r  <= w5r_pkg::w5r_round(dn_r);
    end
  end

  assign y = y_r;
endmodule

@@ sv/w5r_fdiv.sv @@
`timescale 1ns / 1ps
// Pipelined binary64 divider, one restoring quotient bit per stage, DIV_LAT stages.
// Depends on w5r_pkg.
module w5r_fdiv (
  input  logic              clk,
  input  logic              en,
  input  w5r_pkg::w5r_dbl_t a,
  input  w5r_pkg::w5r_dbl_t b,
  output w5r_pkg::w5r_dbl_t y
);
  localparam int unsigned NQ = w5r_pkg::QBITS;

  typedef struct packed {
    logic               sgn;
    logic [1:0]         kind;
    logic signed [12:0] ex;
    logic [52:0]        dv;
    logic [53:0]        rem;
    logic [NQ-1:0]      q;
  } it_t;

  it_t               it_nxt [NQ+1];
  it_t               it_r   [NQ+1];
  w5r_pkg::w5r_unr_t sl_nxt, sl_r, dn_r;
  w5r_pkg::w5r_dbl_t y_r;

  always_comb begin
    logic        an, bn, ai, bi, az, bz;
    logic [52:0] ga, gb;
    logic [10:0] xa, xb;
    logic [7:0]  lza, lzb;
    an  = a[62:52] == 11'h7FF && a[51:0] != '0;
    bn  = b[62:52] == 11'h7FF && b[51:0] != '0;
    ai  = a[62:52] == 11'h7FF && a[51:0] == '0;
    bi  = b[62:52] == 11'h7FF && b[51:0] == '0;
    az  = a[62:0] == '0;
    bz  = b[62:0] == '0;
    xa  = (a[62:52] == '0) ? 11'd1 : a[62:52];
    xb  = (b[62:52] == '0) ? 11'd1 : b[62:52];
    ga  = {a[62:52] != '0, a[51:0]};
    gb  = {b[62:52] != '0, b[51:0]};
    lza = w5r_pkg::w5r_lzc({ga, 75'b0});
    lzb = w5r_pkg::w5r_lzc({gb, 75'b0});
    it_nxt[0].sgn = a[63] ^ b[63];
    it_nxt[0].ex  = 13'(({2'b0, xa} - {5'b0, lza}) - ({2'b0, xb} - {5'b0, lzb})
                       + 13'd1022);
    it_nxt[0].dv  = gb << lzb[5:0];
    it_nxt[0].rem = {1'b0, ga << lza[5:0]};
    it_nxt[0].q   = '0;
    if (an || bn || (az && bz) || (ai && bi)) it_nxt[0].kind = w5r_pkg::KIND_NAN;
    else if (ai || bz)                        it_nxt[0].kind = w5r_pkg::KIND_INF;
    else if (az || bi)                        it_nxt[0].kind = w5r_pkg::KIND_ZERO;
    else                                      it_nxt[0].kind = w5r_pkg::KIND_NUM;
  end

  for (genvar i = 1; i <= NQ; i++) begin : g_it
    always_comb begin
      logic        qb;
      logic [53:0] rs;
      qb = it_r[i-1].rem >= {1'b0, it_r[i-1].dv};
      rs = qb ? (it_r[i-1].rem - {1'b0, it_r[i-1].dv}) : it_r[i-1].rem;
      it_nxt[i]     = it_r[i-1];
      it_nxt[i].rem = {rs[52:0], 1'b0};
      it_nxt[i].q   = {it_r[i-1].q[NQ-2:0], qb};
    end
  end

  always_comb begin
    logic st;
    st          = it_r[NQ].rem != '0;
    sl_nxt.sgn  = it_r[NQ].sgn;
    sl_nxt.kind = it_r[NQ].kind;
    if (it_r[NQ].q[NQ-1]) begin
      sl_nxt.man = {it_r[NQ].q[NQ-1:2], it_r[NQ].q[1] | it_r[NQ].q[0] | st};
      sl_nxt.ex  = it_r[NQ].ex + 13'sd1;
    end else begin
      sl_nxt.man = {it_r[NQ].q[NQ-2:1], it_r[NQ].q[0] | st};
      sl_nxt.ex  = it_r[NQ].ex;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= NQ; i++) it_r[i] <= it_nxt[i];
      sl_r <= sl_nxt;
      dn_r <= w5r_pkg::w5r_denorm(sl_r);
      y_r  <= w5r_pkg::w5r_round(dn_r);
    end
  end

  assign y = y_r;
endmodule

@@ sv/w5r_lane.sv @@
`timescale 1ns / 1ps
// One reconstruction lane: smoothness indicators, weights and stencil blend, LANE_LAT stages.
// Depends on w5r_pkg, w5r_fadd, w5r_fmul, w5r_fdiv, w5r_dly.
module w5r_lane (
  input  logic              clk,
  input  logic              en,
  input  logic              lin_only,
  input  w5r_pkg::w5r_dbl_t p0,
  input  w5r_pkg::w5r_dbl_t p1,
  input  w5r_pkg::w5r_dbl_t p2,
  input  w5r_pkg::w5r_dbl_t p3,
  input  w5r_pkg::w5r_dbl_t p4,
  output w5r_pkg::w5r_dbl_t res
);
  localparam int unsigned A = w5r_pkg::ADD_LAT;
  localparam int unsigned M = w5r_pkg::MUL_LAT;
  localparam int unsigned D = w5r_pkg::DIV_LAT;

  w5r_pkg::w5r_dbl_t m2p0, m2p1, m4p1, m7p1, m2p2, m3p2, m5p2, m11p2, m2p3, m4p3, m5p3;
  w5r_pkg::w5r_dbl_t p0_m, p1_m, p2_m, p2_ma, p3_ma, p4_ma, m3p2_a;
  w5r_pkg::w5r_dbl_t t0a, t0b, t1a, t1b, t2a, t2b;
  w5r_pkg::w5r_dbl_t d1 [3];
  w5r_pkg::w5r_dbl_t d2 [3];
  w5r_pkg::w5r_dbl_t av [3];
  w5r_pkg::w5r_dbl_t sv [3];
  w5r_pkg::w5r_dbl_t pw [3];
  w5r_pkg::w5r_dbl_t sum01, a2_a, wsum, rcp, pw2_a, t01, tfin;
  w5r_pkg::w5r_dbl_t u0, u1, u2, s0x, s1x, s2x, m11p2_a, m2p3_a;
  logic              zs_nxt, zs_d;

  w5r_fmul u_m2p0  (.clk, .en, .a(w5r_pkg::C_TWO),    .b(p0), .y(m2p0));
  w5r_fmul u_m2p1  (.clk, .en, .a(w5r_pkg::C_TWO),    .b(p1), .y(m2p1));
  w5r_fmul u_m4p1  (.clk, .en, .a(w5r_pkg::C_FOUR),   .b(p1), .y(m4p1));
  w5r_fmul u_m7p1  (.clk, .en, .a(w5r_pkg::C_SEVEN),  .b(p1), .y(m7p1));
  w5r_fmul u_m2p2  (.clk, .en, .a(w5r_pkg::C_TWO),    .b(p2), .y(m2p2));
  w5r_fmul u_m3p2  (.clk, .en, .a(w5r_pkg::C_THREE),  .b(p2), .y(m3p2));
  w5r_fmul u_m5p2  (.clk, .en, .a(w5r_pkg::C_FIVE),   .b(p2), .y(m5p2));
  w5r_fmul u_m11p2 (.clk, .en, .a(w5r_pkg::C_ELEVEN), .b(p2), .y(m11p2));
  w5r_fmul u_m2p3  (.clk, .en, .a(w5r_pkg::C_TWO),    .b(p3), .y(m2p3));
  w5r_fmul u_m4p3  (.clk, .en, .a(w5r_pkg::C_FOUR),   .b(p3), .y(m4p3));
  w5r_fmul u_m5p3  (.clk, .en, .a(w5r_pkg::C_FIVE),   .b(p3), .y(m5p3));

  w5r_dly #(.DEPTH(M))   u_dp0  (.clk, .en, .d(p0),   .q(p0_m));
  w5r_dly #(.DEPTH(M))   u_dp1  (.clk, .en, .d(p1),   .q(p1_m));
  w5r_dly #(.DEPTH(M))   u_dp2  (.clk, .en, .d(p2),   .q(p2_m));
  w5r_dly #(.DEPTH(M+A)) u_dp2a (.clk, .en, .d(p2),   .q(p2_ma));
  w5r_dly #(.DEPTH(M+A)) u_dp3a (.clk, .en, .d(p3),   .q(p3_ma));
  w5r_dly #(.DEPTH(M+A)) u_dp4a (.clk, .en, .d(p4),   .q(p4_ma));
  w5r_dly #(.DEPTH(A))   u_d3p2 (.clk, .en, .d(m3p2), .q(m3p2_a));

  // second differences (d1) and first-difference terms (d2) of the three smoothness indicators
  w5r_fadd u_t0a (.clk, .en, .a(p0_m), .b(w5r_pkg::w5r_neg(m2p1)), .y(t0a));
  w5r_fadd u_d10 (.clk, .en, .a(t0a),  .b(p2_ma),                  .y(d1[0]));
  w5r_fadd u_t0b (.clk, .en, .a(p0_m), .b(w5r_pkg::w5r_neg(m4p1)), .y(t0b));
  w5r_fadd u_d20 (.clk, .en, .a(t0b),  .b(m3p2_a),                 .y(d2[0]));

  w5r_fadd u_t1a (.clk, .en, .a(p1_m), .b(w5r_pkg::w5r_neg(m2p2)), .y(t1a));
  w5r_fadd u_d11 (.clk, .en, .a(t1a),  .b(p3_ma),                  .y(d1[1]));
  w5r_fadd u_t1b (.clk, .en, .a(p1),   .b(w5r_pkg::w5r_neg(p3)),   .y(t1b));
  w5r_dly #(.DEPTH(M+A)) u_d21 (.clk, .en, .d(t1b), .q(d2[1]));

  w5r_fadd u_t2a (.clk, .en, .a(p2_m), .b(w5r_pkg::w5r_neg(m2p3)), .y(t2a));
  w5r_fadd u_d12 (.clk, .en, .a(t2a),  .b(p4_ma),                  .y(d1[2]));
  w5r_fadd u_t2b (.clk, .en, .a(m3p2), .b(w5r_pkg::w5r_neg(m4p3)), .y(t2b));
  w5r_fadd u_d22 (.clk, .en, .a(t2b),  .b(p4_ma),                  .y(d2[2]));

  for (genvar k = 0; k < 3; k++) begin : g_beta
    w5r_pkg::w5r_dbl_t sq1, sq2, c1, c2, beta, q, qq;
    w5r_fmul u_sq1 (.clk, .en, .a(d1[k]), .b(d1[k]), .y(sq1));
    w5r_fmul u_sq2 (.clk, .en, .a(d2[k]), .b(d2[k]), .y(sq2));
    w5r_fmul u_c1  (.clk, .en, .a(w5r_pkg::C_BETA_A),  .b(sq1), .y(c1));
    w5r_fmul u_c2  (.clk, .en, .a(w5r_pkg::C_QUARTER), .b(sq2), .y(c2));
    w5r_fadd u_b   (.clk, .en, .a(c1), .b(c2), .y(beta));
    w5r_fadd u_q   (.clk, .en, .a(w5r_pkg::C_EPS), .b(beta), .y(q));
    w5r_fmul u_qq  (.clk, .en, .a(q), .b(q), .y(qq));
    w5r_fdiv u_a   (.clk, .en, .a(w5r_pkg::C_LIN[k]), .b(qq), .y(av[k]));
  end

  w5r_fadd u_s01 (.clk, .en, .a(av[0]), .b(av[1]), .y(sum01));
  w5r_dly #(.DEPTH(A)) u_da2 (.clk, .en, .d(av[2]), .q(a2_a));
  w5r_fadd u_sum (.clk, .en, .a(sum01), .b(a2_a), .y(wsum));
  w5r_fdiv u_rcp (.clk, .en, .a(w5r_pkg::C_ONE), .b(wsum), .y(rcp));

  assign zs_nxt = wsum[62:0] == '0;
  w5r_dly #(.DEPTH(2*M+2*A+D), .W(1)) u_dzs (.clk, .en, .d(zs_nxt), .q(zs_d));

  // stencil values
  w5r_fadd u_u0  (.clk, .en, .a(m2p0), .b(w5r_pkg::w5r_neg(m7p1)), .y(u0));
  w5r_dly #(.DEPTH(A)) u_d11p2 (.clk, .en, .d(m11p2), .q(m11p2_a));
  w5r_fadd u_s0x (.clk, .en, .a(u0), .b(m11p2_a), .y(s0x));
  w5r_fadd u_u1  (.clk, .en, .a(w5r_pkg::w5r_neg(p1_m)), .b(m5p2), .y(u1));
  w5r_dly #(.DEPTH(A)) u_d2p3 (.clk, .en, .d(m2p3), .q(m2p3_a));
  w5r_fadd u_s1x (.clk, .en, .a(u1), .b(m2p3_a), .y(s1x));
  w5r_fadd u_u2  (.clk, .en, .a(m2p2), .b(m5p3), .y(u2));
  w5r_fadd u_s2x (.clk, .en, .a(u2), .b(w5r_pkg::w5r_neg(p4_ma)), .y(s2x));
  w5r_fmul u_s0  (.clk, .en, .a(w5r_pkg::C_SIXTH), .b(s0x), .y(sv[0]));
  w5r_fmul u_s1  (.clk, .en, .a(w5r_pkg::C_SIXTH), .b(s1x), .y(sv[1]));
  w5r_fmul u_s2  (.clk, .en, .a(w5r_pkg::C_SIXTH), .b(s2x), .y(sv[2]));

  for (genvar k = 0; k < 3; k++) begin : g_blend
    w5r_pkg::w5r_dbl_t a_d, w_nl, w_sel, s_d;
    w5r_dly #(.DEPTH(2*A+D)) u_dav (.clk, .en, .d(av[k]), .q(a_d));
    w5r_fmul u_w (.clk, .en, .a(a_d), .b(rcp), .y(w_nl));
    w5r_dly #(.DEPTH(3*M+4*A+2*D)) u_dsv (.clk, .en, .d(sv[k]), .q(s_d));
    assign w_sel = lin_only ? w5r_pkg::C_LIN[k] : w_nl;
    w5r_fmul u_pw (.clk, .en, .a(w_sel), .b(s_d), .y(pw[k]));
  end

  w5r_fadd u_t01 (.clk, .en, .a(pw[0]), .b(pw[1]), .y(t01));
  w5r_dly #(.DEPTH(A)) u_dpw2 (.clk, .en, .d(pw[2]), .q(pw2_a));
  w5r_fadd u_tfin (.clk, .en, .a(t01), .b(pw2_a), .y(tfin));

  assign res = (!lin_only && zs_d) ? w5r_pkg::CANON_NAN : tfin;
endmodule

@@ sv/weno5_face_reconstruction_unit.sv @@
`timescale 1ns / 1ps
// Top level of the WENO5 face reconstruction unit: two lanes and the output stage.
// Depends on w5r_pkg, w5r_in_if, w5r_out_if, w5r_lane.
//
// Accepts one six-cell window (binary64 bit patterns) per clock and returns the left and
// right face states in one transaction, one result per cycle sustained while results are
// taken. The pipeline depth is set by the floating-point pipelines of a lane (two chained
// 61-stage dividers, one quotient bit per stage, dominate). The two lanes run side by
// side, one on each face, and stall together when the result is not taken. cfg_wdata
// selects fixed linear weights; write it only while the unit is empty.
module weno5_face_reconstruction_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  w5r_in_if.sink     in_chan,
  w5r_out_if.source  out_chan
);
  localparam int unsigned LAT = w5r_pkg::LANE_LAT;

  logic              lin_only_r;
  logic              en;
  logic [LAT-1:0]    vld_r;
  logic              out_valid_r;
  w5r_pkg::w5r_dbl_t left_res, right_res;
  w5r_pkg::w5r_dbl_t left_r, right_r;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_only_r <= 1'b0;
    end else if (cfg_we) begin
      lin_only_r <= cfg_wdata;
    end
  end

  w5r_lane u_left (
    .clk, .en, .lin_only(lin_only_r),
    .p0(in_chan.cell_a), .p1(in_chan.cell_b), .p2(in_chan.cell_c),
    .p3(in_chan.cell_d), .p4(in_chan.cell_e), .res(left_res)
  );

  w5r_lane u_right (
    .clk, .en, .lin_only(lin_only_r),
    .p0(in_chan.cell_f), .p1(in_chan.cell_e), .p2(in_chan.cell_d),
    .p3(in_chan.cell_c), .p4(in_chan.cell_b), .res(right_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_chan.valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left_r  <= left_res;
      right_r <= right_res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.left_state  = left_r;
  assign out_chan.right_state = right_r;

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(left_r))
    else $error("pipeline moved during stall");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[LAT-1] |=> out_valid_r)
    else $error("finished transaction not captured");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_chan.ready && !vld_r[LAT-1] |=> !out_valid_r)
    else $error("result repeated after hand-off");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0 && !out_valid_r && !lin_only_r)
    else $error("control state not cleared by reset");
endmodule
